// ----- hw/rtl/osp_pkg.sv -----
// Shared types and constants for the order book snapshot line parser.
`default_nettype none

package osp_pkg;

  // Result kinds carried on the master tuser
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ASK  = 2'd0;
  localparam kind_t KIND_BID  = 2'd1;
  localparam kind_t KIND_MARK = 2'd2;
  localparam kind_t KIND_ERR  = 2'd3;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE    = 2'd0;
  localparam err_t ERR_COUNT   = 2'd1;
  localparam err_t ERR_BAD_INT = 2'd2;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Dropped-level price markers
  localparam logic [63:0] ASK_SENTINEL = 64'd9999999999;
  localparam logic [63:0] BID_SENTINEL = ~ASK_SENTINEL + 64'd1;

  // Accumulator limits (magnitude), checked on a 68-bit scale
  localparam logic [67:0] POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] NEG_LIMIT = 68'h0_8000_0000_0000_0000;

  localparam logic [3:0] LEVELS_RESET = 4'd10;

  // Controller states
  typedef enum logic [2:0] {
    ST_RUN,
    ST_CHECK,
    ST_RD,
    ST_LD,
    ST_MARK,
    ST_ERR,
    ST_HALT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  step;      // process the accepted input word
    logic  rd;        // read an entry from the buffer
    logic  rd_bid;    // read from the bid buffer, else ask
    logic  load;      // load the output register
    kind_t load_kind;
    err_t  load_err;
    logic  load_last;
    logic  clear;     // clear the per-line state
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic line_end_full;  // current input word ends a non-empty line
    logic count_ok;       // field count matches the configured levels
    logic line_bad;       // some field of the line was malformed
    logic out_free;       // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/osp_ctrl.sv -----
// Controller state machine: line end check and result sequencing.
`default_nettype none

module osp_ctrl
  import osp_pkg::*;
#(
  parameter int unsigned CNT_W = 4,
  parameter int unsigned LVL_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire sts_t             sts,
  input  wire logic [CNT_W-1:0] ask_count,
  input  wire logic [CNT_W-1:0] bid_count,
  output cmd_t                  cmd,
  output logic [LVL_W-1:0]      rd_idx
);

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             side, side_next;  // 0 asks, 1 bids
  logic [CNT_W-1:0] idx_plus;

  assign idx_plus = idx + 1'b1;
  assign rd_idx   = idx[LVL_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      idx   <= '0;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      side  <= side_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    side_next  = side;
    case (state)
      ST_RUN: begin
        if (s_tvalid && sts.line_end_full) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        idx_next = '0;
        if (!sts.count_ok || sts.line_bad) begin
          state_next = ST_ERR;
        end else if (ask_count != '0) begin
          side_next  = 1'b0;
          state_next = ST_RD;
        end else if (bid_count != '0) begin
          side_next  = 1'b1;
          state_next = ST_RD;
        end else begin
          state_next = ST_MARK;
        end
      end
      ST_RD: state_next = ST_LD;
      ST_LD: begin
        if (sts.out_free) begin
          if (!side && idx_plus == ask_count) begin
            idx_next   = '0;
            side_next  = 1'b1;
            state_next = (bid_count != '0) ? ST_RD : ST_MARK;
          end else if (side && idx_plus == bid_count) begin
            state_next = ST_MARK;
          end else begin
            idx_next   = idx_plus;
            state_next = ST_RD;
          end
        end
      end
      ST_MARK: begin
        if (sts.out_free) state_next = ST_RUN;
      end
      ST_ERR: begin
        if (sts.out_free) state_next = ST_HALT;
      end
      ST_HALT: state_next = ST_HALT;
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.rd_bid    = side;
    cmd.load_kind = KIND_MARK;
    cmd.load_err  = ERR_NONE;
    case (state)
      ST_RUN: begin
        s_tready = 1'b1;
        cmd.step = s_tvalid;
      end
      ST_RD: cmd.rd = 1'b1;
      ST_LD: begin
        cmd.load      = sts.out_free;
        cmd.load_kind = side ? KIND_BID : KIND_ASK;
      end
      ST_MARK: begin
        cmd.load      = sts.out_free;
        cmd.load_kind = KIND_MARK;
        cmd.load_last = 1'b1;
        cmd.clear     = sts.out_free;
      end
      ST_ERR: begin
        cmd.load      = sts.out_free;
        cmd.load_kind = KIND_ERR;
        cmd.load_err  = sts.count_ok ? ERR_BAD_INT : ERR_COUNT;
        cmd.load_last = 1'b1;
      end
      ST_HALT: s_tready = 1'b1;  // swallow input after an error
      default: s_tready = 1'b0;
    endcase
  end

  // Assertions
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    state == ST_HALT |=> state == ST_HALT)
    else $error("halt state left without reset");

  a_rd_then_ld: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> state == ST_LD)
    else $error("buffer read not followed by output load");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("output loaded while occupied");

  a_no_step_outside_run: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == ST_RUN && s_tready))
    else $error("input processed outside run state");

endmodule

`default_nettype wire

// ----- hw/rtl/osp_datapath.sv -----
// Datapath: field parser, entry buffers, line counter and output register.
`default_nettype none

module osp_datapath
  import osp_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 10,
  parameter int unsigned CNT_W      = 4,
  parameter int unsigned LVL_W      = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       s_tdata,
  input  wire logic             s_tlast,
  input  wire logic             cfg_valid,
  input  wire logic [3:0]       cfg_data,
  input  wire cmd_t             cmd,
  input  wire logic [LVL_W-1:0] rd_idx,
  output sts_t                  sts,
  output logic [CNT_W-1:0]      ask_count,
  output logic [CNT_W-1:0]      bid_count,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [167:0]          m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int unsigned ENT_W   = 128 + LVL_W;
  localparam int unsigned LVL_CAP = (MAX_LEVELS > 15) ? 15 : MAX_LEVELS;

  // Line state
  logic [3:0]       levels;
  logic [63:0]      acc, acc_next;
  logic             neg, neg_next;
  logic             digits, digits_next;
  logic [15:0]      field_pos, field_pos_next;
  logic             field_bad, field_bad_next;
  logic             line_bad, line_bad_next;
  logic             pcr, pcr_next;
  logic             nonempty, nonempty_next;
  logic [63:0]      held, held_next;
  logic [CNT_W-1:0] ask_count_next, bid_count_next;
  logic [31:0]      line_counter, line_counter_next;

  // Entry buffers
  logic [ENT_W-1:0] ask_mem [MAX_LEVELS];
  logic [ENT_W-1:0] bid_mem [MAX_LEVELS];
  logic [ENT_W-1:0] rd_data;

  // Output register
  logic [63:0] out_price, out_size;
  logic [3:0]  out_level;
  err_t        out_err;
  logic [31:0] out_line;
  kind_t       out_kind;
  logic        out_last;

  // Input decode
  logic is_lf, is_cr, is_comma, is_minus, is_digit, line_end;
  assign is_lf    = (s_tdata == CH_LF);
  assign is_cr    = (s_tdata == CH_CR);
  assign is_comma = (s_tdata == CH_COMMA);
  assign is_minus = (s_tdata == CH_MINUS);
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign line_end = s_tlast ? (nonempty || pcr) : is_lf;

  // Next decimal digit with overflow check: acc*10 + d against the limit
  logic [67:0] acc_x10, acc_sum, acc_lim;
  logic        acc_over;
  assign acc_x10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
  assign acc_sum  = acc_x10 + {64'd0, s_tdata[3:0]};
  assign acc_lim  = neg ? NEG_LIMIT : POS_LIMIT;
  assign acc_over = (acc_sum > acc_lim);

  // Field completion; a pending CR before a comma counts as a bad character
  logic             fin_fb, fin_ok, lvl_in, ask_we, bid_we;
  logic [63:0]      value;
  logic [1:0]       role;
  logic [LVL_W-1:0] fin_lvl;
  assign fin_fb  = line_end ? field_bad : (field_bad || pcr);
  assign fin_ok  = !fin_fb && digits;
  assign value   = neg ? (64'd0 - acc) : acc;
  assign role    = field_pos[1:0];
  assign lvl_in  = (field_pos[15:2] < 14'(MAX_LEVELS));
  assign fin_lvl = field_pos[LVL_W+1:2];

  logic do_fin;
  assign do_fin = cmd.step && ((line_end && nonempty) ||
                               (!line_end && !s_tlast && !is_cr && is_comma));
  assign ask_we = do_fin && fin_ok && lvl_in && (role == 2'd1) &&
                  (held != ASK_SENTINEL) && (value != 64'd0) &&
                  (ask_count < CNT_W'(MAX_LEVELS));
  assign bid_we = do_fin && fin_ok && lvl_in && (role == 2'd3) &&
                  (held != BID_SENTINEL) && (value != 64'd0) &&
                  (bid_count < CNT_W'(MAX_LEVELS));

  // Line state next values
  always_comb begin
    acc_next          = acc;
    neg_next          = neg;
    digits_next       = digits;
    field_pos_next    = field_pos;
    field_bad_next    = field_bad;
    line_bad_next     = line_bad;
    pcr_next          = pcr;
    nonempty_next     = nonempty;
    held_next         = held;
    ask_count_next    = ask_count;
    bid_count_next    = bid_count;
    line_counter_next = line_counter;
    if (cmd.clear) begin
      acc_next       = '0;
      neg_next       = 1'b0;
      digits_next    = 1'b0;
      field_pos_next = '0;
      field_bad_next = 1'b0;
      line_bad_next  = 1'b0;
      pcr_next       = 1'b0;
      nonempty_next  = 1'b0;
      held_next      = '0;
      ask_count_next = '0;
      bid_count_next = '0;
    end else if (cmd.step) begin
      if (line_end) begin
        line_counter_next = line_counter + 32'd1;
        if (!nonempty) begin
          // empty line: counted, then dropped
          acc_next       = '0;
          neg_next       = 1'b0;
          digits_next    = 1'b0;
          field_pos_next = '0;
          field_bad_next = 1'b0;
          line_bad_next  = 1'b0;
          pcr_next       = 1'b0;
          held_next      = '0;
          ask_count_next = '0;
          bid_count_next = '0;
        end
      end else if (!s_tlast) begin
        if (is_cr) begin
          // a second CR makes the first one ordinary content
          if (pcr) begin
            field_bad_next = 1'b1;
            nonempty_next  = 1'b1;
          end
          pcr_next = 1'b1;
        end else begin
          pcr_next       = 1'b0;
          nonempty_next  = 1'b1;
          field_bad_next = field_bad || pcr;
          if (!is_comma && !(field_bad || pcr)) begin
            if (is_minus && !digits && !neg) begin
              neg_next = 1'b1;
            end else if (is_digit) begin
              if (acc_over) begin
                field_bad_next = 1'b1;
              end else begin
                acc_next    = acc_sum[63:0];
                digits_next = 1'b1;
              end
            end else begin
              field_bad_next = 1'b1;
            end
          end
        end
      end
      if (do_fin) begin
        if (!fin_ok) line_bad_next = 1'b1;
        if (fin_ok && lvl_in && !role[0]) held_next = value;
        if (ask_we) ask_count_next = ask_count + 1'b1;
        if (bid_we) bid_count_next = bid_count + 1'b1;
        if (field_pos != 16'hFFFF) field_pos_next = field_pos + 16'd1;
        acc_next       = '0;
        neg_next       = 1'b0;
        digits_next    = 1'b0;
        field_bad_next = 1'b0;
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      neg          <= 1'b0;
      digits       <= 1'b0;
      field_pos    <= '0;
      field_bad    <= 1'b0;
      line_bad     <= 1'b0;
      pcr          <= 1'b0;
      nonempty     <= 1'b0;
      held         <= '0;
      ask_count    <= '0;
      bid_count    <= '0;
      line_counter <= '0;
    end else begin
      acc          <= acc_next;
      neg          <= neg_next;
      digits       <= digits_next;
      field_pos    <= field_pos_next;
      field_bad    <= field_bad_next;
      line_bad     <= line_bad_next;
      pcr          <= pcr_next;
      nonempty     <= nonempty_next;
      held         <= held_next;
      ask_count    <= ask_count_next;
      bid_count    <= bid_count_next;
      line_counter <= line_counter_next;
    end
  end

  // Levels register
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LEVELS_RESET;
    end else if (cfg_valid) begin
      levels <= cfg_data;
    end
  end

  // Entry buffers: one write, one registered read each
  always_ff @(posedge clk) begin
    if (ask_we) ask_mem[ask_count[LVL_W-1:0]] <= {fin_lvl, value, held};
    if (bid_we) bid_mem[bid_count[LVL_W-1:0]] <= {fin_lvl, value, held};
    if (cmd.rd) rd_data <= cmd.rd_bid ? bid_mem[rd_idx] : ask_mem[rd_idx];
  end

  // Field count check against saturated levels
  logic [3:0] eff;
  assign eff = (levels > 4'(LVL_CAP)) ? 4'(LVL_CAP) : levels;

  // Entry fields of the read word
  logic [LVL_W+3:0] lvl_ext;
  logic             is_entry;
  assign lvl_ext  = {4'b0000, rd_data[128 +: LVL_W]};
  assign is_entry = (cmd.load_kind == KIND_ASK) || (cmd.load_kind == KIND_BID);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= cmd.load || (m_tvalid && !m_tready);
    end
    if (cmd.load) begin
      out_price <= is_entry ? rd_data[63:0] : 64'd0;
      out_size  <= is_entry ? rd_data[127:64] : 64'd0;
      out_level <= is_entry ? lvl_ext[3:0] : 4'd0;
      out_err   <= cmd.load_err;
      out_line  <= line_counter;
      out_kind  <= cmd.load_kind;
      out_last  <= cmd.load_last;
    end
  end

  assign m_tdata = {2'b00, out_line, out_err, out_level, out_size, out_price};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  assign sts.line_end_full = cmd.step ? (line_end && nonempty) : (line_end && nonempty);
  assign sts.count_ok      = (field_pos == {10'd0, eff, 2'b00});
  assign sts.line_bad      = line_bad;
  assign sts.out_free      = !m_tvalid || m_tready;

  // Assertions
  a_ask_bound: assert property (@(posedge clk) disable iff (rst)
    ask_count <= CNT_W'(MAX_LEVELS))
    else $error("ask buffer overfilled");

  a_bid_bound: assert property (@(posedge clk) disable iff (rst)
    bid_count <= CNT_W'(MAX_LEVELS))
    else $error("bid buffer overfilled");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (ask_count == '0 && bid_count == '0 && field_pos == '0))
    else $error("line state not cleared");

endmodule

`default_nettype wire

// ----- hw/rtl/orderbook_snapshot_csv_parser.sv -----
// Top level of the order book snapshot CSV line parser.
//
// Slave stream: one text byte per word in s_tdata; s_tlast marks end of input
// (the byte is then ignored and any pending line is completed).
// Master stream: one result per word. m_tuser holds the kind (ask, bid, end of
// snapshot, error); m_tlast marks the final result of the causing input word.
// Config channel: cfg_data sets the levels per line; always ready.
// Throughput: one byte per cycle while inside a line. A byte that ends a
// non-empty line starts a burst: the field count check, then a buffer read
// and an output load for each kept entry, then the end-of-snapshot or error
// word. Input is not taken during that burst; after the last word is loaded
// input resumes even while it waits.
// A receiver stall holds the output register and the sequence with it.
// Reset clears all line state, the line counter and the error halt; levels
// returns to 10. After an error, input is accepted and dropped until reset.
`default_nettype none

module orderbook_snapshot_csv_parser
  import osp_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // char_byte
  input  wire logic         s_tlast,   // end_of_input
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // price[63:0], size[127:64], level_index[131:128], error_code[133:132],
  // line_number[165:134], zero pad[167:166]
  output logic [167:0]      m_tdata,
  output logic [1:0]        m_tuser,   // kind
  output logic              m_tlast,   // last
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data   // levels
);

  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] ask_count, bid_count;
  logic [LVL_W-1:0] rd_idx;

  assign cfg_ready = 1'b1;

  osp_ctrl #(
    .CNT_W (CNT_W),
    .LVL_W (LVL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sts       (sts),
    .ask_count (ask_count),
    .bid_count (bid_count),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

  osp_datapath #(
    .MAX_LEVELS (MAX_LEVELS),
    .CNT_W      (CNT_W),
    .LVL_W      (LVL_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .sts       (sts),
    .ask_count (ask_count),
    .bid_count (bid_count),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ----- verif/tb_orderbook_snapshot_csv_parser.sv -----
// Self-checking testbench for the order book snapshot CSV line parser.
`default_nettype none

module tb_orderbook_snapshot_csv_parser;
  import osp_pkg::*;

  localparam int MAX_LVL = 10;
  localparam int DRAIN   = 60;         // covers the longest line-end burst
  localparam int HOLD    = 400;        // long receiver hold-off
  localparam int LIMIT   = 1_200_000;  // watchdog, in clock cycles

  // One output word as seen on the master stream
  typedef struct packed {
    kind_t       kind;
    logic [63:0] price;
    logic [63:0] qty;
    logic [3:0]  lvl;
    err_t        err;
    logic [31:0] line;
    logic        last;
  } book_word_t;

  // One kept book level waiting for the end of its line
  typedef struct packed {
    logic [63:0] price;
    logic [63:0] qty;
    logic [3:0]  lvl;
  } level_t;

  // Stimulus row: optional levels write, leading commas, text, end of input
  typedef struct {
    int    cfg;
    int    commas;
    string txt;
    bit    eoi;
    bit    typed;
    kind_t kind;
    err_t  err;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_data = '0;

  orderbook_snapshot_csv_parser #(.MAX_LEVELS(MAX_LVL)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // char_byte
    .s_tlast  (s_tlast),    // end_of_input
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // price, size, level_index, error_code, line_number, pad
    .m_tuser  (m_tuser),    // kind
    .m_tlast  (m_tlast),    // last
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)    // levels
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected words, oldest first
  book_word_t book_q [$];
  int fails = 0;
  int cycles = 0;
  int sent_words = 0;
  bit mute = 1'b0;
  bit tx_calm = 1'b0;
  logic hold_go = 1'b0;

  // Parser state mirror
  logic [3:0]  lv_cfg;
  logic [63:0] acc;
  bit          neg, dig, fbad, lbad, pcr, lne, halted;
  logic [15:0] fpos;
  logic [63:0] hprice;
  level_t      ask_buf [MAX_LVL];
  level_t      bid_buf [MAX_LVL];
  int          ask_n, bid_n;
  logic [31:0] line_no;

  // Directed rows; typed rows carry their single expected word
  row_t dir_rows [16] = '{
    '{-1, 0, "0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0\n",
      0, 1, KIND_MARK, ERR_NONE},
    '{1, 0, "100,5,99,7\n", 0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "9999999999,5,-9999999999,7\n", 0, 1, KIND_MARK, ERR_NONE},
    '{-1, 0, "9223372036854775807,-9223372036854775808,-9223372036854775808,9223372036854775807\n",
      0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "\n", 0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "\r\n", 0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "1,2,3,4\r\n", 0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "0,-1,00,0042\n", 0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "-0,7,5,0", 1, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "", 1, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "\r", 1, 0, KIND_ASK, ERR_NONE},
    '{15, 0, "10,1,9,1,11,2,8,2,12,0,7,3,9999999999,4,6,4,14,5,-9999999999,5,",
      0, 0, KIND_ASK, ERR_NONE},
    '{-1, 0, "15,6,4,6,16,7,3,0,17,8,2,8,18,9,1,9,19,10,0,10\n", 0, 0, KIND_ASK, ERR_NONE},
    '{2, 0, "5,0,6,0,7,8,9,10\n", 0, 0, KIND_ASK, ERR_NONE},
    '{1, 0, "1,2,3,4", 0, 0, KIND_ASK, ERR_NONE},
    '{2, 0, ",5,6,7,8\n", 0, 0, KIND_ASK, ERR_NONE}
  };

  // Closing faults; one is picked per run since an error halts the block
  row_t fault_rows [8] = '{
    '{1, 0, "1,2,3\n", 0, 1, KIND_ERR, ERR_COUNT},
    '{1, 0, "1,x,3\n", 0, 1, KIND_ERR, ERR_COUNT},
    '{1, 0, "1,2a,-,1-2\n", 0, 1, KIND_ERR, ERR_BAD_INT},
    '{1, 0, "1,9223372036854775808,3,-9223372036854775809\n", 0, 1, KIND_ERR, ERR_BAD_INT},
    '{1, 0, "1,2,3,4\r\r\n", 0, 1, KIND_ERR, ERR_BAD_INT},
    '{1, 0, "1,,3,4\n", 0, 1, KIND_ERR, ERR_BAD_INT},
    '{0, 0, "1,2,3,4\n", 0, 1, KIND_ERR, ERR_COUNT},
    '{1, 0, "1,2,3,4,5\n", 0, 1, KIND_ERR, ERR_COUNT}
  };

  // ---------------------------------------------------------------- predictor

  task automatic clear_line();
    acc = '0;
    neg = 1'b0;
    dig = 1'b0;
    fpos = '0;
    fbad = 1'b0;
    lbad = 1'b0;
    pcr = 1'b0;
    lne = 1'b0;
    hprice = '0;
    ask_n = 0;
    bid_n = 0;
  endtask

  task automatic book_reset();
    lv_cfg = LEVELS_RESET;
    clear_line();
    line_no = '0;
    halted = 1'b0;
  endtask

  task automatic emit(kind_t k, logic [63:0] p, logic [63:0] q, logic [3:0] l, err_t e,
                      logic lst);
    book_word_t w;
    w.kind = k;
    w.price = p;
    w.qty = q;
    w.lvl = l;
    w.err = e;
    w.line = line_no;
    w.last = lst;
    if (!mute) book_q = {book_q, w};
  endtask

  // Digit, sign or junk inside a field
  task automatic take_char(logic [7:0] c);
    logic [63:0] d, lim;
    lne = 1'b1;
    if (!fbad) begin
      if (c == CH_MINUS && !dig && !neg) begin
        neg = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        d = 64'(c - CH_ZERO);
        lim = neg ? NEG_LIMIT[63:0] : POS_LIMIT[63:0];
        if (acc > (lim - d) / 64'd10) begin
          fbad = 1'b1;
        end else begin
          acc = acc * 64'd10 + d;
          dig = 1'b1;
        end
      end else begin
        fbad = 1'b1;
      end
    end
  endtask

  // Comma or line end: file the field by its role within the level
  task automatic close_field();
    logic [63:0] v;
    int lvl, role;
    v = neg ? (~acc + 64'd1) : acc;
    lvl = int'(fpos) / 4;
    role = int'(fpos) % 4;
    if (fbad || !dig) begin
      lbad = 1'b1;
    end else if (lvl < MAX_LVL) begin
      if (role == 0 || role == 2) begin
        hprice = v;
      end else if (role == 1) begin
        if (hprice != ASK_SENTINEL && v != '0 && ask_n < MAX_LVL) begin
          ask_buf[ask_n] = '{hprice, v, 4'(lvl)};
          ask_n++;
        end
      end else begin
        if (hprice != BID_SENTINEL && v != '0 && bid_n < MAX_LVL) begin
          bid_buf[bid_n] = '{hprice, v, 4'(lvl)};
          bid_n++;
        end
      end
    end
    if (fpos != 16'hFFFF) fpos++;
    acc = '0;
    neg = 1'b0;
    dig = 1'b0;
    fbad = 1'b0;
  endtask

  task automatic close_line();
    int eff;
    line_no++;
    if (lne) begin
      close_field();
      eff = (lv_cfg > MAX_LVL) ? MAX_LVL : int'(lv_cfg);
      if (fpos != 16'(4 * eff)) begin
        emit(KIND_ERR, '0, '0, '0, ERR_COUNT, 1'b1);
        halted = 1'b1;
      end else if (lbad) begin
        emit(KIND_ERR, '0, '0, '0, ERR_BAD_INT, 1'b1);
        halted = 1'b1;
      end else begin
        for (int i = 0; i < ask_n; i++)
          emit(KIND_ASK, ask_buf[i].price, ask_buf[i].qty, ask_buf[i].lvl, ERR_NONE, 1'b0);
        for (int i = 0; i < bid_n; i++)
          emit(KIND_BID, bid_buf[i].price, bid_buf[i].qty, bid_buf[i].lvl, ERR_NONE, 1'b0);
        emit(KIND_MARK, '0, '0, '0, ERR_NONE, 1'b1);
      end
    end
    clear_line();
  endtask

  task automatic parse_byte(logic [7:0] b, logic eoi);
    if (halted) begin
      // dropped until reset
    end else if (eoi) begin
      if (lne || pcr) close_line();
    end else if (b == CH_LF) begin
      close_line();
    end else if (b == CH_CR) begin
      if (pcr) take_char(CH_CR);
      pcr = 1'b1;
    end else begin
      if (pcr) begin
        take_char(CH_CR);
        pcr = 1'b0;
      end
      if (b == CH_COMMA) begin
        lne = 1'b1;
        close_field();
      end else begin
        take_char(b);
      end
    end
  endtask

  // ---------------------------------------------------------------- sender

  function automatic int tx_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word; valid stays high on return so a back-to-back word follows
  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_words++;
    parse_byte(b, eoi);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_word(s[k], 1'b0);
  endtask

  // Wait until the block has drained, then write the levels register
  task automatic set_levels(logic [3:0] v);
    s_tvalid <= 1'b0;
    while (book_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lv_cfg = v;
  endtask

  task automatic run_row(row_t r);
    book_word_t w;
    if (r.cfg >= 0) set_levels(4'(r.cfg));
    tx_calm = ($urandom_range(0, 3) == 0) || (r.commas > 0);
    mute = r.typed;
    repeat (r.commas) send_word(CH_COMMA, 1'b0);
    send_text(r.txt);
    if (r.eoi) send_word(8'($urandom_range(0, 255)), 1'b1);
    mute = 1'b0;
    if (r.typed) begin
      w = '0;
      w.kind = r.kind;
      w.err = r.err;
      w.line = line_no;
      w.last = 1'b1;
      book_q = {book_q, w};
    end
  endtask

  // One well-formed decimal field; prices lean to sentinels, sizes to zero
  function automatic string field_text(int role);
    logic [63:0] v, mag;
    bit minus;
    int r;
    string sign, pad;
    r = $urandom_range(0, 99);
    if (role % 2 == 0 && r < 20) begin
      v = (role == 0) ? ASK_SENTINEL : BID_SENTINEL;
    end else if (role % 2 == 0 && r < 25) begin
      v = (role == 0) ? BID_SENTINEL : ASK_SENTINEL;
    end else if (role % 2 == 1 && r < 20) begin
      v = '0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        v = 64'($urandom_range(0, 999));
        if ($urandom_range(0, 3) == 0) v = ~v + 64'd1;
      end else if (r < 55) begin
        case ($urandom_range(0, 3))
          0: v = 64'h7FFF_FFFF_FFFF_FFFF;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FFF_FFFF_FFFF_FFFE;
          default: v = 64'h8000_0000_0000_0001;
        endcase
      end else begin
        v = {$urandom, $urandom};
      end
    end
    minus = v[63];
    mag = minus ? (~v + 64'd1) : v;
    if (v == '0 && $urandom_range(0, 3) == 0) minus = 1'b1;
    sign = "";
    if (minus) sign = "-";
    pad = "";
    if ($urandom_range(0, 9) == 0) pad = "00";
    return {sign, pad, $sformatf("%0d", mag)};
  endfunction

  // Random phases of well-formed lines at assorted level counts
  task automatic random_lines();
    int start_words, roll, lv, eff, nl;
    bit first, calm_set;
    string s;
    start_words = sent_words;
    first = 1'b1;
    while (sent_words - start_words < 160) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) lv = 1;
      else if (roll < 65) lv = 2;
      else if (roll < 80) lv = 3;
      else if (roll < 90) lv = $urandom_range(4, 9);
      else lv = $urandom_range(10, 15);
      // short back-to-back lines first, so the long hold-off backs up the input
      if (first) lv = 1;
      set_levels(4'(lv));
      calm_set = first;
      if (first) begin
        hold_go <= 1'b1;
        first = 1'b0;
      end
      eff = (lv > MAX_LVL) ? MAX_LVL : lv;
      nl = calm_set ? 2 : ((eff >= 4) ? 1 : $urandom_range(1, 5));
      repeat (nl) begin
        tx_calm = calm_set || ($urandom_range(0, 2) == 0);
        // occasional empty line ahead of the real one
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: send_text("\n");
            1: send_text("\r\n");
            2: send_word(8'($urandom_range(0, 255)), 1'b1);
            default: begin
              send_text("\r");
              send_word(8'($urandom_range(0, 255)), 1'b1);
            end
          endcase
        end
        s = "";
        for (int f = 0; f < 4 * eff; f++) begin
          s = {s, field_text(f % 4)};
          if (f != 4 * eff - 1) s = {s, ","};
        end
        send_text(s);
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_text("\n");
        end else if (roll < 85) begin
          send_text("\r\n");
        end else if (roll < 95) begin
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          send_text("\r");
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  task automatic cmp_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fails++;
    end
  endtask

  task automatic check_word();
    book_word_t e;
    if (book_q.size() == 0) begin
      $display("%0t: unexpected word: kind %0d line %0d", $time, m_tuser, m_tdata[165:134]);
      fails++;
    end else begin
      e = book_q.pop_front();
      cmp_field("kind", 64'(e.kind), 64'(m_tuser));
      cmp_field("price", e.price, m_tdata[63:0]);
      cmp_field("size", e.qty, m_tdata[127:64]);
      cmp_field("level_index", 64'(e.lvl), 64'(m_tdata[131:128]));
      cmp_field("error_code", 64'(e.err), 64'(m_tdata[133:132]));
      cmp_field("line_number", 64'(e.line), 64'(m_tdata[165:134]));
      cmp_field("last", 64'(e.last), 64'(m_tlast));
    end
  endtask

  int rx_roll = 0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  bit hold_done = 1'b0;

  // Take words with random stalls, one long hold-off, and calm stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_word();
      rx_roll = $urandom_range(0, 99);
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD;
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (cycles[9:8] != 2'd0 && rx_roll < 25)
          stall_cnt <= (rx_roll < 2) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[orderbook_snapshot_csv_parser] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    book_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) run_row(dir_rows[i]);
    random_lines();
    // closing fault, then input that the halted block must drop
    run_row(fault_rows[$urandom_range(0, 7)]);
    tx_calm = 1'b0;
    repeat (40) send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    send_text("1,2,3,4\n");
    s_tvalid <= 1'b0;
    while (book_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("[orderbook_snapshot_csv_parser] OK");
    end else begin
      $display("[orderbook_snapshot_csv_parser] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
